// ===== src/bpvi_pkg.sv =====
// ----------------------------------------------------------------------------
// bpvi_pkg
// Shared types, operation codes and constants of the patch volume integrator.
// ----------------------------------------------------------------------------
package bpvi_pkg;

    localparam int IDX_W   = 10;
    localparam int STEP_W  = 17;
    localparam int AREA_W  = 20;
    localparam int CFG_W   = 20;
    localparam int CFGI_W  = 2;
    localparam int Q_W     = 18;   // rounded Q1.16 products
    localparam int B_W     = 19;   // basis values, up to three times one
    localparam int S_W     = 24;   // inner sums of the difference net
    localparam int MUL_W   = 24;   // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int HACC_W  = 46;
    localparam int H_W     = 22;
    localparam int W_W     = 27;
    localparam int VOL_W   = 32;

    localparam logic [STEP_W-1:0] ONE_Q16 = STEP_W'(65536);
    localparam logic [H_W-1:0]    H_MAX   = H_W'(2097151);

    // register indexes
    localparam logic [CFGI_W-1:0] REG_LAST_INDEX = 2'd0;
    localparam logic [CFGI_W-1:0] REG_STEP_RECIP = 2'd1;
    localparam logic [CFGI_W-1:0] REG_TILE_AREA  = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_T    = 4'd1;
    localparam logic [3:0] OP_OM2  = 4'd2;
    localparam logic [3:0] OP_T2   = 4'd3;
    localparam logic [3:0] OP_B0   = 4'd4;
    localparam logic [3:0] OP_B1   = 4'd5;
    localparam logic [3:0] OP_B2   = 4'd6;
    localparam logic [3:0] OP_B3   = 4'd7;
    localparam logic [3:0] OP_ACC  = 4'd8;
    localparam logic [3:0] OP_HGT  = 4'd9;
    localparam logic [3:0] OP_WGT  = 4'd10;

    typedef struct packed {
        logic       load;     // latch a new word
        logic [3:0] op;
        logic       lane_v;   // t and basis ops work on v when set
        logic [1:0] sel;      // row for the accumulate op
        logic       commit;   // update volume and fill the output slot
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // top minus bottom control heights, row pairs with bu, column with bv
    function automatic logic [3:0] diff_net(input logic [1:0] i, input logic [1:0] j);
        logic [15:0] row;
        case (i)
            2'd0:    row = {4'd6, 4'd0, 4'd3, 4'd0};
            2'd1:    row = {4'd0, 4'd6, 4'd2, 4'd4};
            2'd2:    row = {4'd11, 4'd0, 4'd3, 4'd0};
            default: row = {4'd6, 4'd10, 4'd0, 4'd0};
        endcase
        return row[j*4 +: 4];
    endfunction

endpackage

// ===== src/bezier_patch_volume_integrator.sv =====
// ----------------------------------------------------------------------------
// bezier_patch_volume_integrator
// Bicubic patch height and weighted volume sum, one grid node per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per grid node: node_u,
//   node_v and final_node. Output channel (out_valid/out_ready) returns one
//   word per node: node_height (Q6.16), running_volume (Q16.16, saturating)
//   and volume_done, set on the word of the final node, after which the
//   accumulator restarts from zero.
//   Configuration: write cfg_data to register cfg_index while cfg_wr_en is
//   high (0 last_index, 1 step_recip, 2 tile_area), only while idle.
//   A new node is accepted only once the current one has committed; the single
//   shared 24x24 multiplier runs seven steps per axis, four row products, one
//   weight product, plus load, height and commit steps.
//   A result waiting in the output register does not block acceptance of the
//   next node; if the receiver stalls, the sequencer holds at its commit step.
//   Reset: registers return to last_index 1023, step_recip 64, tile_area 1;
//   the accumulator and output slot clear.
// ----------------------------------------------------------------------------
module bezier_patch_volume_integrator
    import bpvi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFGI_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IDX_W-1:0]        node_u,
    input  logic [IDX_W-1:0]        node_v,
    input  logic                    final_node,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [H_W-1:0]   node_height,
    output logic signed [VOL_W-1:0] running_volume,
    output logic                    volume_done
);

    cmd_t    cmd;
    status_t status;

    // sequencer: walks the multiplier schedule
    bpvi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, configuration and output slot
    bpvi_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .node_u         (node_u),
        .node_v         (node_v),
        .final_node     (final_node),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .node_height    (node_height),
        .running_volume (running_volume),
        .volume_done    (volume_done)
    );

endmodule

// ===== src/bpvi_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpvi_ctrl
// Sequencer: steps the shared multiplier through the per-node schedule.
// ----------------------------------------------------------------------------
module bpvi_ctrl
    import bpvi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [4:0] LAST_STEP = 5'd19;

    logic [1:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] k;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        k          = (step_reg >= 5'd7) ? step_reg - 5'd7 : step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg < 5'd14)
                begin
                    cmd.lane_v = (step_reg >= 5'd7);
                    case (k)
                        5'd0:    cmd.op = OP_T;
                        5'd1:    cmd.op = OP_OM2;
                        5'd2:    cmd.op = OP_T2;
                        5'd3:    cmd.op = OP_B0;
                        5'd4:    cmd.op = OP_B1;
                        5'd5:    cmd.op = OP_B2;
                        default: cmd.op = OP_B3;
                    endcase
                end
                else if (step_reg < 5'd18)
                begin
                    cmd.op  = OP_ACC;
                    cmd.sel = 2'(step_reg - 5'd14);
                end
                else if (step_reg == 5'd18)
                    cmd.op = OP_HGT;
                else
                    cmd.op = OP_WGT;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output slot can take the word
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/bpvi_datapath.sv =====
// ----------------------------------------------------------------------------
// bpvi_datapath
// Configuration, shared multiplier, basis and sum registers, volume and output.
// ----------------------------------------------------------------------------
module bpvi_datapath
    import bpvi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFGI_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic [IDX_W-1:0]        node_u,
    input  logic [IDX_W-1:0]        node_v,
    input  logic                    final_node,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [H_W-1:0]   node_height,
    output logic signed [VOL_W-1:0] running_volume,
    output logic                    volume_done
);

    logic [IDX_W-1:0]  last_reg;
    logic [STEP_W-1:0] step_reg;
    logic [AREA_W-1:0] area_reg;

    logic [IDX_W-1:0]  iu_reg, iv_reg;
    logic              fin_reg, edge_u_reg, edge_v_reg;
    logic [STEP_W-1:0] t_reg;
    logic [Q_W-1:0]    om2_reg, t2_reg;
    logic [B_W-1:0]    bu_reg [4];
    logic [B_W-1:0]    bv_reg [4];
    logic [HACC_W-1:0] hacc_reg;
    logic [H_W-1:0]    h_reg;
    logic [W_W-1:0]    w_reg;
    logic signed [VOL_W-1:0] acc_reg;
    logic              out_valid_reg;

    logic [STEP_W-1:0] om;
    logic [MUL_W-1:0]  opa, opb;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    rnd;
    logic [B_W-1:0]    b_next;
    logic [S_W-1:0]    s [4];
    logic [HACC_W-1:0] h_round;
    logic [H_W-1:0]    h_next;
    logic [W_W-1:0]    w_next;
    logic signed [VOL_W+1:0] sum;
    logic signed [VOL_W-1:0] acc_next;

    assign om = ONE_Q16 - t_reg;

    // inner sums over the v bases, constant weights only
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s[i] = '0;
            for (int j = 0; j < 4; j++)
                s[i] = s[i] + S_W'(bv_reg[j]) * S_W'(diff_net(2'(i), 2'(j)));
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.op)
            OP_T:
            begin
                opa = MUL_W'(cmd.lane_v ? iv_reg : iu_reg);
                opb = MUL_W'(step_reg);
            end
            OP_OM2: begin opa = MUL_W'(om);      opb = MUL_W'(om);      end
            OP_T2:  begin opa = MUL_W'(t_reg);   opb = MUL_W'(t_reg);   end
            OP_B0:  begin opa = MUL_W'(om2_reg); opb = MUL_W'(om);      end
            OP_B1:  begin opa = MUL_W'(t_reg);   opb = MUL_W'(om2_reg); end
            OP_B2:  begin opa = MUL_W'(t2_reg);  opb = MUL_W'(om);      end
            OP_B3:  begin opa = MUL_W'(t2_reg);  opb = MUL_W'(t_reg);   end
            OP_ACC: begin opa = MUL_W'(bu_reg[cmd.sel]); opb = s[cmd.sel]; end
            OP_WGT: begin opa = MUL_W'(h_reg);   opb = MUL_W'(area_reg); end
            default: ;
        endcase
    end

    assign prod = opa * opb;
    assign rnd  = Q_W'((prod + PROD_W'(32768)) >> 16);

    always_comb
    begin
        case (cmd.op)
            OP_B1, OP_B2: b_next = B_W'(rnd) * B_W'(3);
            default:      b_next = B_W'(rnd);
        endcase
    end

    assign h_round = (hacc_reg + HACC_W'(32768)) >> 16;
    assign h_next  = (h_round > HACC_W'(H_MAX)) ? H_MAX : H_W'(h_round);

    // corner, edge and interior weights
    always_comb
    begin
        if (edge_u_reg && edge_v_reg)
            w_next = W_W'((prod + PROD_W'(1 << 17)) >> 18);
        else if (edge_u_reg || edge_v_reg)
            w_next = W_W'((prod + PROD_W'(1 << 16)) >> 17);
        else
            w_next = W_W'((prod + PROD_W'(1 << 15)) >> 16);
    end

    assign sum = (VOL_W+2)'(acc_reg) + (VOL_W+2)'($signed({1'b0, w_reg}));
    always_comb
    begin
        if (sum > (VOL_W+2)'(32'sh7FFFFFFF))
            acc_next = 32'sh7FFFFFFF;
        else if (sum < -(VOL_W+2)'(34'sh080000000))
            acc_next = 32'sh80000000;
        else
            acc_next = VOL_W'(sum);
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= IDX_W'(1023);
            step_reg      <= STEP_W'(64);
            area_reg      <= AREA_W'(1);
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LAST_INDEX: last_reg <= cfg_data[IDX_W-1:0];
                    REG_STEP_RECIP: step_reg <= cfg_data[STEP_W-1:0];
                    REG_TILE_AREA:  area_reg <= cfg_data[AREA_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.commit)
            begin
                // clear after the sweep total goes out
                acc_reg       <= fin_reg ? '0 : acc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            iu_reg     <= node_u;
            iv_reg     <= node_v;
            fin_reg    <= final_node;
            edge_u_reg <= (node_u == '0) || (node_u == last_reg);
            edge_v_reg <= (node_v == '0) || (node_v == last_reg);
            hacc_reg   <= '0;
        end
        case (cmd.op)
            OP_T:
                t_reg <= (prod > PROD_W'(ONE_Q16)) ? ONE_Q16 : STEP_W'(prod);
            OP_OM2: om2_reg <= rnd;
            OP_T2:  t2_reg  <= rnd;
            OP_B0, OP_B1, OP_B2, OP_B3:
            begin
                if (cmd.lane_v)
                    bv_reg[2'(cmd.op - OP_B0)] <= b_next;
                else
                    bu_reg[2'(cmd.op - OP_B0)] <= b_next;
            end
            OP_ACC: hacc_reg <= hacc_reg + HACC_W'(prod);
            OP_HGT: h_reg    <= h_next;
            OP_WGT: w_reg    <= w_next;
            default: ;
        endcase
        if (cmd.commit)
        begin
            node_height    <= $signed(h_reg);
            running_volume <= acc_next;
            volume_done    <= fin_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("output slot overwritten");
    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && fin_reg |=> acc_reg == '0)
        else $error("volume not cleared after final word");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.commit && cmd.op == OP_NONE)
        else $error("load during active step");

endmodule
